// ----- src/cpcr_pkg.sv -----
// Package for the circle pair collision resolver: field types, pipeline
// sideband record, unit sizes and rounding/saturation helpers.
// No dependencies.
package cpcr_pkg;

    localparam int COORD_W   = 24;
    localparam int RAD_W     = 16;
    localparam int REG_W     = 17;
    localparam int CFG_IDX_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REST = 4'd1;

    localparam logic [REG_W-1:0] GAIN_RST = 17'd65536;
    localparam logic [REG_W-1:0] REST_RST = 17'd32768;
    localparam logic [17:0]      ONE_Q16  = 18'd65536;

    // square root unit: 50-bit radicand, one root bit per stage
    localparam int SQ_STAGES = 25;
    localparam int SQ_IN_W   = 50;
    localparam int SQ_W      = 51;
    localparam int SQ_OUT_W  = 25;

    // divider unit: one quotient bit per stage
    localparam int DV_STAGES = 29;
    localparam int DV_NUM_W  = 45;
    localparam int DV_DEN_W  = 25;
    localparam int DV_CMP_W  = 54;

    localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (COORD_W - 1)) - 64'sd1;
    localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        t_coord           pos_a_x;
        t_coord           pos_a_y;
        t_coord           pos_b_x;
        t_coord           pos_b_y;
        t_coord           vel_a_x;
        t_coord           vel_a_y;
        t_coord           vel_b_x;
        t_coord           vel_b_y;
        logic [RAD_W-1:0] radius_a;
        logic [RAD_W-1:0] radius_b;
    } t_in;

    typedef struct packed {
        t_coord new_pos_a_x;
        t_coord new_pos_a_y;
        t_coord new_pos_b_x;
        t_coord new_pos_b_y;
        t_coord new_vel_a_x;
        t_coord new_vel_a_y;
        t_coord new_vel_b_x;
        t_coord new_vel_b_y;
        logic   overlapped;
        logic   impulse_applied;
    } t_out;

    typedef struct packed {
        t_coord             pa_x;
        t_coord             pa_y;
        t_coord             pb_x;
        t_coord             pb_y;
        t_coord             va_x;
        t_coord             va_y;
        t_coord             vb_x;
        t_coord             vb_y;
        logic [RAD_W-1:0]   ra;
        logic [RAD_W-1:0]   rb;
        logic [RAD_W:0]     diam;
        logic signed [24:0] rv_x;
        logic signed [24:0] rv_y;
        logic signed [17:0] dx;
        logic signed [17:0] dy;
        logic [24:0]        dlen;
        logic signed [17:0] nx;
        logic signed [17:0] ny;
        logic               hit;
        logic               app;
        logic               j_neg;
    } t_side;

    // shift right by s >= 1, round to nearest, halves away from zero
    function automatic logic signed [63:0] f_rnd_shr(input logic signed [63:0] v,
                                                     input int unsigned s);
        logic [63:0] mag;
        logic [63:0] q;
        mag = v[63] ? 64'(-v) : 64'(v);
        q   = (mag + (64'd1 << (s - 1))) >> s;
        return v[63] ? -$signed(q) : $signed(q);
    endfunction

    function automatic t_coord f_sat(input logic signed [63:0] v);
        if (v > SAT_HI) begin
            return COORD_W'(SAT_HI);
        end else if (v < SAT_LO) begin
            return COORD_W'(SAT_LO);
        end
        return COORD_W'(v);
    endfunction

endpackage

// ----- src/cpcr_isqrt.sv -----
// Pipelined integer square root, one root bit per register stage.
// Carries the cpcr_pkg sideband record alongside. Depends on cpcr_pkg.
module cpcr_isqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_vld,
    input  logic [cpcr_pkg::SQ_IN_W-1:0]  i_val,
    input  cpcr_pkg::t_side               i_side,
    output logic                          o_vld,
    output logic [cpcr_pkg::SQ_OUT_W-1:0] o_root,
    output cpcr_pkg::t_side               o_side
);
    import cpcr_pkg::*;

    logic            r_vld  [SQ_STAGES];
    logic [SQ_W-1:0] r_rem  [SQ_STAGES];
    logic [SQ_W-1:0] r_res  [SQ_STAGES];
    t_side           r_side [SQ_STAGES];

    for (genvar k = 0; k < SQ_STAGES; k++) begin : g_st
        logic            w_vld;
        logic [SQ_W-1:0] w_rem;
        logic [SQ_W-1:0] w_res;
        logic [SQ_W-1:0] w_bit;
        logic [SQ_W-1:0] w_try;
        t_side           w_side;

        if (k == 0) begin : g_first
            assign w_vld  = i_vld;
            assign w_rem  = SQ_W'(i_val);
            assign w_res  = '0;
            assign w_side = i_side;
        end else begin : g_next
            assign w_vld  = r_vld[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_res  = r_res[k-1];
            assign w_side = r_side[k-1];
        end

        assign w_bit = SQ_W'(1) << (2 * (SQ_STAGES - 1 - k));
        assign w_try = w_res + w_bit;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_side[k] <= w_side;
            if (w_rem >= w_try) begin
                r_rem[k] <= w_rem - w_try;
                r_res[k] <= (w_res >> 1) + w_bit;
            end else begin
                r_rem[k] <= w_rem;
                r_res[k] <= w_res >> 1;
            end
        end
    end

    assign o_vld  = r_vld[SQ_STAGES-1];
    assign o_root = r_res[SQ_STAGES-1][SQ_OUT_W-1:0];
    assign o_side = r_side[SQ_STAGES-1];

endmodule

// ----- src/cpcr_div.sv -----
// Pipelined restoring divider, one quotient bit per register stage.
// Carries the cpcr_pkg sideband record alongside. Depends on cpcr_pkg.
module cpcr_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_vld,
    input  logic [cpcr_pkg::DV_NUM_W-1:0] i_num,
    input  logic [cpcr_pkg::DV_DEN_W-1:0] i_den,
    input  cpcr_pkg::t_side               i_side,
    output logic                          o_vld,
    output logic [cpcr_pkg::DV_STAGES-1:0] o_q,
    output cpcr_pkg::t_side               o_side
);
    import cpcr_pkg::*;

    logic                 r_vld  [DV_STAGES];
    logic [DV_NUM_W-1:0]  r_rem  [DV_STAGES];
    logic [DV_DEN_W-1:0]  r_den  [DV_STAGES];
    logic [DV_STAGES-1:0] r_q    [DV_STAGES];
    t_side                r_side [DV_STAGES];

    for (genvar k = 0; k < DV_STAGES; k++) begin : g_st
        logic                 w_vld;
        logic [DV_NUM_W-1:0]  w_rem;
        logic [DV_DEN_W-1:0]  w_den;
        logic [DV_STAGES-1:0] w_q;
        logic [DV_CMP_W-1:0]  w_sh;
        logic [DV_CMP_W-1:0]  w_dif;
        logic                 w_ge;
        t_side                w_side;

        if (k == 0) begin : g_first
            assign w_vld  = i_vld;
            assign w_rem  = i_num;
            assign w_den  = i_den;
            assign w_q    = '0;
            assign w_side = i_side;
        end else begin : g_next
            assign w_vld  = r_vld[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_den  = r_den[k-1];
            assign w_q    = r_q[k-1];
            assign w_side = r_side[k-1];
        end

        assign w_sh  = DV_CMP_W'(w_den) << (DV_STAGES - 1 - k);
        assign w_ge  = DV_CMP_W'(w_rem) >= w_sh;
        assign w_dif = DV_CMP_W'(w_rem) - w_sh;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_side[k] <= w_side;
            r_den[k]  <= w_den;
            if (w_ge) begin
                r_rem[k] <= w_dif[DV_NUM_W-1:0];
                r_q[k]   <= w_q | (DV_STAGES'(1) << (DV_STAGES - 1 - k));
            end else begin
                r_rem[k] <= w_rem;
                r_q[k]   <= w_q;
            end
        end
    end

    assign o_vld  = r_vld[DV_STAGES-1];
    assign o_q    = r_q[DV_STAGES-1];
    assign o_side = r_side[DV_STAGES-1];

endmodule

// ----- src/circle_pair_collision_resolve.sv -----
// Circle pair collision resolver, top level: front stages, square root,
// normal division, push/impulse math, impulse division, output register.
// Depends on cpcr_pkg, cpcr_isqrt, cpcr_div.
//
//  channel   | handshake                    | payload
//  ----------+------------------------------+-------------------------------
//  request   | start, busy                  | i_req (t_in)
//  result    | o_res_valid (strobe)         | o_res (t_out)
//  config    | i_cfg_valid, o_cfg_ready     | i_cfg_index, i_cfg_data
//
// One request per cycle while busy is low, fully pipelined; each result
// passes through 15 math stages, the 25-stage square root and two
// 29-stage divider steps in series. busy is high only during reset and the
// first cycle after it. Results cannot be stalled; o_cfg_ready is always high.
module circle_pair_collision_resolve (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  cpcr_pkg::t_in                  i_req,
    output logic                           o_res_valid,
    output cpcr_pkg::t_out                 o_res,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [cpcr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [cpcr_pkg::REG_W-1:0]     i_cfg_data
);
    import cpcr_pkg::*;

    logic             r_busy;
    logic [REG_W-1:0] r_gain;
    logic [REG_W-1:0] r_rest;
    logic             w_acc;

    assign busy        = r_busy;
    assign o_cfg_ready = 1'b1;
    assign w_acc       = start && !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_gain <= GAIN_RST;
            r_rest <= REST_RST;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_GAIN: r_gain <= i_cfg_data;
                    CFG_REST: r_rest <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // stage 0: differences, diameter, bounding box test
    logic signed [24:0] w_dx, w_dy, w_adx, w_ady;
    logic [RAD_W:0]     w_diam;
    t_side              n0_s;
    logic               r0_vld;
    t_side              r0_s;

    always_comb begin
        w_dx   = 25'(i_req.pos_a_x) - 25'(i_req.pos_b_x);
        w_dy   = 25'(i_req.pos_a_y) - 25'(i_req.pos_b_y);
        w_adx  = w_dx[24] ? -w_dx : w_dx;
        w_ady  = w_dy[24] ? -w_dy : w_dy;
        w_diam = 17'(i_req.radius_a) + 17'(i_req.radius_b);
        n0_s      = '0;
        n0_s.pa_x = i_req.pos_a_x;
        n0_s.pa_y = i_req.pos_a_y;
        n0_s.pb_x = i_req.pos_b_x;
        n0_s.pb_y = i_req.pos_b_y;
        n0_s.va_x = i_req.vel_a_x;
        n0_s.va_y = i_req.vel_a_y;
        n0_s.vb_x = i_req.vel_b_x;
        n0_s.vb_y = i_req.vel_b_y;
        n0_s.ra   = i_req.radius_a;
        n0_s.rb   = i_req.radius_b;
        n0_s.diam = w_diam;
        n0_s.rv_x = 25'(i_req.vel_a_x) - 25'(i_req.vel_b_x);
        n0_s.rv_y = 25'(i_req.vel_a_y) - 25'(i_req.vel_b_y);
        n0_s.dx   = 18'(w_dx);
        n0_s.dy   = 18'(w_dy);
        n0_s.hit  = (w_dx != 25'sd0 || w_dy != 25'sd0)
                 && ($unsigned(w_adx) < 25'(w_diam))
                 && ($unsigned(w_ady) < 25'(w_diam));
    end

    // stage 1: squares
    logic               r1_vld;
    t_side              r1_s;
    logic signed [35:0] r1_sqx, r1_sqy;
    logic [33:0]        r1_dd;

    // stage 2: distance test, radicand
    logic signed [35:0]   w_d2;
    logic                 r2_vld;
    t_side                r2_s;
    logic [SQ_IN_W-1:0]   r2_v;

    assign w_d2 = r1_sqx + r1_sqy;

    logic                sq_vld;
    logic [SQ_OUT_W-1:0] sq_root;
    t_side               sq_side;

    cpcr_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r2_vld),
        .i_val   (r2_v),
        .i_side  (r2_s),
        .o_vld   (sq_vld),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // stage 3: normal numerators
    logic [16:0]         w_adx3, w_ady3;
    logic                r3_vld;
    t_side               r3_s;
    logic [DV_NUM_W-1:0] r3_numx, r3_numy;

    assign w_adx3 = 17'(sq_side.dx[17] ? -sq_side.dx : sq_side.dx);
    assign w_ady3 = 17'(sq_side.dy[17] ? -sq_side.dy : sq_side.dy);

    logic                 dvx_vld;
    logic [DV_STAGES-1:0] dvx_q, dvy_q;
    t_side                dvx_side;

    cpcr_div u_div_nx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r3_vld),
        .i_num   (r3_numx),
        .i_den   (r3_s.dlen),
        .i_side  (r3_s),
        .o_vld   (dvx_vld),
        .o_q     (dvx_q),
        .o_side  (dvx_side)
    );

    cpcr_div u_div_ny (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r3_vld),
        .i_num   (r3_numy),
        .i_den   (r3_s.dlen),
        .i_side  (r3_s),
        .o_vld   (),
        .o_q     (dvy_q),
        .o_side  ()
    );

    // stage 4: signed normal, overlap
    logic signed [17:0] w_qx, w_qy;
    logic               r4_vld;
    t_side              r4_s;
    logic [24:0]        r4_ovl;

    assign w_qx = $signed(18'(dvx_q));
    assign w_qy = $signed(18'(dvy_q));

    // stage 5: normal times gain, relative velocity times normal
    logic               r5_vld;
    t_side              r5_s;
    logic [24:0]        r5_ovl;
    logic signed [35:0] r5_ngx, r5_ngy;
    logic signed [42:0] r5_mx, r5_my;

    // stage 6: times overlap, normal speed
    logic               r6_vld;
    t_side              r6_s;
    logic signed [61:0] r6_ngox, r6_ngoy;
    logic signed [43:0] r6_dot;

    // stage 7: push and normal speed rounding
    logic               r7_vld;
    t_side              r7_s;
    logic signed [18:0] r7_px, r7_py;
    logic signed [26:0] r7_vn;

    // stage 8: positions, restitution product
    logic [17:0]        w_kf;
    logic               r8_vld;
    t_side              r8_s;
    logic signed [45:0] r8_k;

    assign w_kf = ONE_Q16 + 18'(r_rest);

    // stage 9: impulse
    logic               r9_vld;
    t_side              r9_s;
    logic signed [28:0] r9_j;

    // stage 10: mass weighting products
    logic [27:0]        w_aj;
    logic               r10_vld;
    t_side              r10_s;
    logic [43:0]        r10_nja, r10_njb;

    assign w_aj = 28'(r9_j[28] ? -r9_j : r9_j);

    // stage 11: impulse share numerators
    logic                r11_vld;
    t_side               r11_s;
    logic [DV_NUM_W-1:0] r11_numa, r11_numb;

    logic                 dva_vld;
    logic [DV_STAGES-1:0] dva_q, dvb_q;
    t_side                dva_side;

    cpcr_div u_div_ja (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r11_vld),
        .i_num   (r11_numa),
        .i_den   (DV_DEN_W'(r11_s.diam)),
        .i_side  (r11_s),
        .o_vld   (dva_vld),
        .o_q     (dva_q),
        .o_side  (dva_side)
    );

    cpcr_div u_div_jb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r11_vld),
        .i_num   (r11_numb),
        .i_den   (DV_DEN_W'(r11_s.diam)),
        .i_side  (r11_s),
        .o_vld   (),
        .o_q     (dvb_q),
        .o_side  ()
    );

    // stage 12: signed shares
    logic signed [29:0] w_qa, w_qb;
    logic               r12_vld;
    t_side              r12_s;
    logic signed [29:0] r12_ja, r12_jb;

    assign w_qa = $signed(30'(dva_q));
    assign w_qb = $signed(30'(dvb_q));

    // stage 13: velocity delta products
    logic               r13_vld;
    t_side              r13_s;
    logic signed [47:0] r13_dax, r13_day, r13_dbx, r13_dby;

    // stage 14: output register
    t_out  n14_o;
    logic  r14_vld;
    t_out  r14_o;

    always_comb begin
        n14_o.new_pos_a_x     = r13_s.pa_x;
        n14_o.new_pos_a_y     = r13_s.pa_y;
        n14_o.new_pos_b_x     = r13_s.pb_x;
        n14_o.new_pos_b_y     = r13_s.pb_y;
        n14_o.new_vel_a_x     = r13_s.va_x;
        n14_o.new_vel_a_y     = r13_s.va_y;
        n14_o.new_vel_b_x     = r13_s.vb_x;
        n14_o.new_vel_b_y     = r13_s.vb_y;
        n14_o.overlapped      = r13_s.hit;
        n14_o.impulse_applied = r13_s.app;
        if (r13_s.app) begin
            n14_o.new_vel_a_x = f_sat(64'(r13_s.va_x) - f_rnd_shr(64'(r13_dax), 16));
            n14_o.new_vel_a_y = f_sat(64'(r13_s.va_y) - f_rnd_shr(64'(r13_day), 16));
            n14_o.new_vel_b_x = f_sat(64'(r13_s.vb_x) + f_rnd_shr(64'(r13_dbx), 16));
            n14_o.new_vel_b_y = f_sat(64'(r13_s.vb_y) + f_rnd_shr(64'(r13_dby), 16));
        end
    end

    // sideband updates per stage
    t_side n2_s, n3_s, n4_s, n7_s, n8_s, n10_s;

    always_comb begin
        n2_s        = r1_s;
        n2_s.hit    = r1_s.hit && ($unsigned(w_d2) < 36'(r1_dd));
        n3_s        = sq_side;
        n3_s.dlen   = sq_root;
        n4_s        = dvx_side;
        n4_s.nx     = dvx_side.dx[17] ? -w_qx : w_qx;
        n4_s.ny     = dvx_side.dy[17] ? -w_qy : w_qy;
        n7_s        = r6_s;
        n7_s.app    = r6_s.hit && r6_dot[43];
        n8_s        = r7_s;
        if (r7_s.hit) begin
            n8_s.pa_x = f_sat(64'(r7_s.pa_x) + 64'(r7_px));
            n8_s.pa_y = f_sat(64'(r7_s.pa_y) + 64'(r7_py));
            n8_s.pb_x = f_sat(64'(r7_s.pb_x) - 64'(r7_px));
            n8_s.pb_y = f_sat(64'(r7_s.pb_y) - 64'(r7_py));
        end
        n10_s       = r9_s;
        n10_s.j_neg = r9_j[28];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld  <= 1'b0;
            r1_vld  <= 1'b0;
            r2_vld  <= 1'b0;
            r3_vld  <= 1'b0;
            r4_vld  <= 1'b0;
            r5_vld  <= 1'b0;
            r6_vld  <= 1'b0;
            r7_vld  <= 1'b0;
            r8_vld  <= 1'b0;
            r9_vld  <= 1'b0;
            r10_vld <= 1'b0;
            r11_vld <= 1'b0;
            r12_vld <= 1'b0;
            r13_vld <= 1'b0;
            r14_vld <= 1'b0;
        end else begin
            r0_vld  <= w_acc;
            r1_vld  <= r0_vld;
            r2_vld  <= r1_vld;
            r3_vld  <= sq_vld;
            r4_vld  <= dvx_vld;
            r5_vld  <= r4_vld;
            r6_vld  <= r5_vld;
            r7_vld  <= r6_vld;
            r8_vld  <= r7_vld;
            r9_vld  <= r8_vld;
            r10_vld <= r9_vld;
            r11_vld <= r10_vld;
            r12_vld <= dva_vld;
            r13_vld <= r12_vld;
            r14_vld <= r13_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r0_s <= n0_s;

        r1_s   <= r0_s;
        r1_sqx <= 36'(r0_s.dx) * 36'(r0_s.dx);
        r1_sqy <= 36'(r0_s.dy) * 36'(r0_s.dy);
        r1_dd  <= 34'(r0_s.diam) * 34'(r0_s.diam);

        r2_s <= n2_s;
        r2_v <= n2_s.hit ? {w_d2[33:0], 16'b0} : '0;

        r3_s    <= n3_s;
        r3_numx <= DV_NUM_W'({w_adx3, 24'b0}) + DV_NUM_W'(sq_root >> 1);
        r3_numy <= DV_NUM_W'({w_ady3, 24'b0}) + DV_NUM_W'(sq_root >> 1);

        r4_s   <= n4_s;
        r4_ovl <= 25'({dvx_side.diam, 8'b0}) - dvx_side.dlen;

        r5_s   <= r4_s;
        r5_ovl <= r4_ovl;
        r5_ngx <= 36'(r4_s.nx) * 36'($signed({1'b0, r_gain}));
        r5_ngy <= 36'(r4_s.ny) * 36'($signed({1'b0, r_gain}));
        r5_mx  <= 43'(r4_s.rv_x) * 43'(r4_s.nx);
        r5_my  <= 43'(r4_s.rv_y) * 43'(r4_s.ny);

        r6_s    <= r5_s;
        r6_ngox <= 62'(r5_ngx) * 62'($signed({1'b0, r5_ovl}));
        r6_ngoy <= 62'(r5_ngy) * 62'($signed({1'b0, r5_ovl}));
        r6_dot  <= 44'(r5_mx) + 44'(r5_my);

        r7_s  <= n7_s;
        r7_px <= 19'(f_rnd_shr(64'(r6_ngox), 41));
        r7_py <= 19'(f_rnd_shr(64'(r6_ngoy), 41));
        r7_vn <= 27'(f_rnd_shr(64'(r6_dot), 16));

        r8_s <= n8_s;
        r8_k <= 46'(r7_vn) * 46'($signed({1'b0, w_kf}));

        r9_s <= r8_s;
        r9_j <= 29'(f_rnd_shr(64'(r8_k), 16));

        r10_s   <= n10_s;
        r10_nja <= 44'(w_aj) * 44'(r9_s.rb);
        r10_njb <= 44'(w_aj) * 44'(r9_s.ra);

        r11_s    <= r10_s;
        r11_numa <= DV_NUM_W'(r10_nja) + DV_NUM_W'(r10_s.diam >> 1);
        r11_numb <= DV_NUM_W'(r10_njb) + DV_NUM_W'(r10_s.diam >> 1);

        r12_s  <= dva_side;
        r12_ja <= dva_side.j_neg ? -w_qa : w_qa;
        r12_jb <= dva_side.j_neg ? -w_qb : w_qb;

        r13_s   <= r12_s;
        r13_dax <= 48'(r12_s.nx) * 48'(r12_ja);
        r13_day <= 48'(r12_s.ny) * 48'(r12_ja);
        r13_dbx <= 48'(r12_s.nx) * 48'(r12_jb);
        r13_dby <= 48'(r12_s.ny) * 48'(r12_jb);

        r14_o <= n14_o;
    end

    assign o_res_valid = r14_vld;
    assign o_res       = r14_o;

    a_imp_needs_ovl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.impulse_applied |-> o_res.overlapped)
        else $error("impulse flagged without overlap");

    a_unit_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r4_vld && r4_s.hit |-> (r4_s.nx <= 18'sd65536) && (r4_s.nx >= -18'sd65536)
                            && (r4_s.ny <= 18'sd65536) && (r4_s.ny >= -18'sd65536))
        else $error("normal component out of unit range");

    a_busy_after_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("busy low right after reset");

    a_no_res_after_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_valid)
        else $error("result strobe right after reset");

endmodule
